/* design/spf_pkg.sv */
// shared types, defaults and register codes of the spectrum peak finder
package spf_pkg;

	localparam int MAX_PEAKS_DEF  = 16;
	localparam int MAX_POINTS_DEF = 4096;
	localparam int AMP_BITS_DEF   = 32;

	localparam int AMP_W   = 32;
	localparam int BIN_W   = 12;
	localparam int FREQ_W  = 44;
	localparam int COUNT_W = 5;
	localparam int DIST_W  = 13;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_HEIGHT   = 2'd0,
		REG_MIN_DISTANCE = 2'd1,
		REG_BIN_WIDTH    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude;
		logic             last_sample;
	} sample_t;

	typedef struct packed {
		logic              peak_valid;
		logic [AMP_W-1:0]  peak_amp;
		logic [BIN_W-1:0]  peak_bin;
		logic [FREQ_W-1:0] peak_freq;
		logic [COUNT_W-1:0] peak_count;
		logic              last_result;
	} peak_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

endpackage

/* design/spf_stream_if.sv */
// valid/ready channel carrying one payload item
interface spf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* design/spectrum_peak_finder_core.sv */
// spectrum peak finder: streaming peak picker with result table and drain
//
// samples: one magnitude per item, the final bin of a spectrum marked by
// last_sample. an item is taken in every cycle while no table drain runs;
// each bin is judged in the cycle its right neighbour is accepted, against
// both neighbours, the height threshold and the distance to the last peak.
// peaks: on the final bin the stored peaks are sent out, one item per
// cycle while peaks is not stalled, or one item with peak_valid low when
// none were found. the first result passes the drain flag, the table
// read and the frequency multiply into the output register; the drain
// reads the peak table through its single read port, one entry per item.
// samples is held off during the drain.
// cfg: index and data of one register per item, always ready; write only
// while the block is idle.
// reset clears the neighbour history, bin counter, peak count and all
// handshake state; cfg registers return to zero. a stall on peaks holds the
// output register and the table read stage, and the drain waits with them.
module spectrum_peak_finder_core #(
	parameter int MAX_PEAKS  = spf_pkg::MAX_PEAKS_DEF,
	parameter int MAX_POINTS = spf_pkg::MAX_POINTS_DEF,
	parameter int AMP_BITS   = spf_pkg::AMP_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	spf_stream_if.sink   samples,
	spf_stream_if.source peaks,
	spf_stream_if.sink   cfg
);

	localparam int BC_W   = $clog2(MAX_POINTS + 1);
	localparam int BIN_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
	localparam int IDX_W  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam int CMP_W  = (AMP_BITS > spf_pkg::AMP_W) ? AMP_BITS : spf_pkg::AMP_W;

	logic [spf_pkg::AMP_W-1:0]  min_height_q;
	logic [spf_pkg::DIST_W-1:0] min_distance_q;
	logic [spf_pkg::AMP_W-1:0]  bin_width_q;

	logic [AMP_BITS-1:0] older_q, newer_q, last_store_amp_q;
	logic [BC_W-1:0]     bc_q;
	logic [BIN_W-1:0]    last_peak_bin_q;
	logic                have_peak_q;
	logic [CNT_W-1:0]    count_q;

	logic                drain_q;
	logic [CNT_W-1:0]    drain_total_q;
	logic [IDX_W-1:0]    rd_idx_q;

	logic [AMP_BITS-1:0] amp_mem [MAX_PEAKS];
	logic [BIN_W-1:0]    bin_mem [MAX_PEAKS];

	logic                valid_s1;
	logic                pv_s1, last_s1;
	logic [CNT_W-1:0]    count_s1;
	logic [AMP_BITS-1:0] amp_s1;
	logic [BIN_W-1:0]    bin_s1;

	logic                out_valid_q;
	spf_pkg::peak_t      out_q;

	logic [AMP_BITS-1:0] amp_in;
	logic [BIN_W-1:0]    cand;
	logic [BIN_W-1:0]    bin_gap;
	logic                in_acc, in_range, is_peak, dist_ok, full, do_store;
	logic [IDX_W-1:0]    wr_idx;
	logic [CNT_W-1:0]    count_next;
	logic                out_adv, issue, issue_last;
	logic [spf_pkg::BIN_W-1:0] bin_o;

	assign samples.ready = !drain_q;
	assign cfg.ready     = 1'b1;
	assign in_acc        = samples.valid && samples.ready;

	// per-bin judgement
	always_comb begin
		amp_in   = AMP_BITS'(samples.payload.amplitude);
		in_range = (bc_q >= BC_W'(2)) && (bc_q <= BC_W'(MAX_POINTS - 1));
		cand     = BIN_W'(bc_q - BC_W'(1));
		bin_gap  = cand - last_peak_bin_q;
		is_peak  = (CMP_W'(newer_q) > CMP_W'(min_height_q)) && (newer_q > older_q)
			&& (newer_q > amp_in);
		dist_ok  = !have_peak_q || (32'(bin_gap) > 32'(min_distance_q));
		full     = (count_q == CNT_W'(MAX_PEAKS));
		do_store = in_acc && in_range && is_peak && dist_ok
			&& (!full || (newer_q > last_store_amp_q));
		wr_idx   = full ? IDX_W'(MAX_PEAKS - 1) : IDX_W'(count_q);
		count_next = (do_store && !full) ? count_q + CNT_W'(1) : count_q;
	end

	assign out_adv    = !out_valid_q || peaks.ready;
	assign issue      = drain_q && (!valid_s1 || out_adv);
	assign issue_last = (drain_total_q == '0)
		|| (CNT_W'(rd_idx_q) == drain_total_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_height_q    <= '0;
			min_distance_q  <= '0;
			bin_width_q     <= '0;
			older_q         <= '0;
			newer_q         <= '0;
			bc_q            <= '0;
			last_peak_bin_q <= '0;
			have_peak_q     <= 1'b0;
			count_q         <= '0;
			drain_q         <= 1'b0;
			drain_total_q   <= '0;
			rd_idx_q        <= '0;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.payload.index)
					spf_pkg::REG_MIN_HEIGHT:   min_height_q <= cfg.payload.data;
					spf_pkg::REG_MIN_DISTANCE:
						min_distance_q <= cfg.payload.data[spf_pkg::DIST_W-1:0];
					spf_pkg::REG_BIN_WIDTH:    bin_width_q <= cfg.payload.data;
					default: ;
				endcase
			end
			if (in_acc) begin
				if (samples.payload.last_sample) begin
					older_q         <= '0;
					newer_q         <= '0;
					bc_q            <= '0;
					last_peak_bin_q <= '0;
					have_peak_q     <= 1'b0;
					count_q         <= '0;
					drain_q         <= 1'b1;
					drain_total_q   <= count_next;
					rd_idx_q        <= '0;
				end else begin
					older_q <= newer_q;
					newer_q <= amp_in;
					if (bc_q != BC_W'(MAX_POINTS))
						bc_q <= bc_q + BC_W'(1);
					if (do_store) begin
						last_peak_bin_q <= cand;
						have_peak_q     <= 1'b1;
					end
					count_q <= count_next;
				end
			end
			if (issue) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
				if (issue_last)
					drain_q <= 1'b0;
			end
			if (issue)
				valid_s1 <= 1'b1;
			else if (out_adv)
				valid_s1 <= 1'b0;
			if (out_adv)
				out_valid_q <= valid_s1;
		end
	end

	// peak table
	always_ff @(posedge clk) begin
		if (do_store) begin
			amp_mem[wr_idx]  <= newer_q;
			bin_mem[wr_idx]  <= cand;
			last_store_amp_q <= newer_q;
		end
	end

	// table read stage
	always_ff @(posedge clk) begin
		if (issue) begin
			amp_s1   <= amp_mem[rd_idx_q];
			bin_s1   <= bin_mem[rd_idx_q];
			pv_s1    <= (drain_total_q != '0);
			last_s1  <= issue_last;
			count_s1 <= drain_total_q;
		end
	end

	assign bin_o = pv_s1 ? spf_pkg::BIN_W'(bin_s1) : '0;

	// output register with frequency product
	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			out_q.peak_valid  <= pv_s1;
			out_q.peak_amp    <= pv_s1 ? spf_pkg::AMP_W'(amp_s1) : '0;
			out_q.peak_bin    <= bin_o;
			out_q.peak_freq   <= spf_pkg::FREQ_W'(bin_o) * spf_pkg::FREQ_W'(bin_width_q);
			out_q.peak_count  <= spf_pkg::COUNT_W'(count_s1);
			out_q.last_result <= last_s1;
		end
	end

	assign peaks.valid   = out_valid_q;
	assign peaks.payload = out_q;

`ifndef SYNTHESIS
	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && samples.payload.last_sample) |=> drain_q)
		else $error("final bin did not start the table drain");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PEAKS))
		else $error("peak count beyond table depth");
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !peaks.ready) |=> valid_s1)
		else $error("read stage lost an item under stall");
	a_drain_index: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_q && drain_total_q != '0) |-> (CNT_W'(rd_idx_q) < drain_total_q))
		else $error("drain index ran past stored peaks");
`endif

endmodule
